// ===== hw/rtl/albtd_pkg.sv =====
// Shared types and constants for the alarm LED / buzzer tone driver.
// No dependencies; imported by albtd_div, albtd_timing and the top level.
`default_nettype none

package albtd_pkg;

  localparam int P_W     = 20;  // period, high time, low time, phase count
  localparam int CNT_W   = 26;  // burst period count
  localparam int DIVD_W  = 27;  // divider dividend / quotient
  localparam int STEP_W  = 5;   // divider step counter
  localparam int FREQ_W  = 20;
  localparam int DUTY_W  = 7;
  localparam int PULSE_W = 16;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 20;

  localparam logic [FREQ_W-1:0] FREQ_FALLBACK = 20'd2731;
  localparam logic [P_W-1:0]    DUTY_DIV      = 20'd100;

  // Divider step counts; the period and burst dividends are left-aligned to DIVD_W
  localparam logic [STEP_W-1:0] STEPS_PERIOD = 5'd20;
  localparam logic [STEP_W-1:0] STEPS_HIGH   = 5'd27;
  localparam logic [STEP_W-1:0] STEPS_BURST  = 5'd26;

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } albtd_cmd_t;

  typedef enum logic [IDX_W-1:0] {
    REG_FREQ      = 3'd0,
    REG_DUTY      = 3'd1,
    REG_PULSE     = 3'd2,
    REG_LED_AH    = 3'd3,
    REG_BUZ_AH    = 3'd4,
    REG_WAVE_EN   = 3'd5
  } albtd_reg_t;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_ISSUE_P,
    TS_WAIT_P,
    TS_ISSUE_H,
    TS_WAIT_H,
    TS_ISSUE_C,
    TS_WAIT_C,
    TS_FINISH
  } albtd_tstate_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [P_W-1:0]    divisor;
    logic [STEP_W-1:0] steps;
  } albtd_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } albtd_div_rsp_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [P_W-1:0]   high;
    logic [P_W-1:0]   low;
    logic [CNT_W-1:0] cycles;
  } albtd_timing_t;

endpackage

`default_nettype wire

// ===== hw/rtl/alarm_led_buzzer_tone_driver.sv =====
// Top level of the alarm LED / buzzer tone driver: config registers, wave state,
// tick logic and output register. Depends on albtd_pkg; instantiates albtd_timing.
//
//   Channel  Direction  Handshake             Payload
//   in_      sink       in_valid / in_ready   command, led_request, buzzer_request,
//                                             wave_request
//   out_     source     out_valid / out_ready led_pin, sounder_pin, on_mask, bursts_left
//   cfg_     sink       cfg_valid / cfg_ready cfg_index (3 b), cfg_data (20 b)
//
// For tick commands and static set commands the result is registered at the
// transfer edge. A wave set command runs the timing sequencer on the shared
// one-bit-per-cycle divider: 20 steps for the period, 27 for the high time and,
// with a nonzero pulse length, 26 for the burst count. The result is loaded when
// the sequencer finishes, and in_ready stays low meanwhile. The output register
// lets a new input transfer happen in the same cycle the pending result is taken.
// Reset is synchronous, active low; it loads the config defaults and clears the
// LED/buzzer state. cfg_ready is always high.
`default_nettype none

module alarm_led_buzzer_tone_driver #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic                                in_led_request,
  input  logic                                in_buzzer_request,
  input  logic                                in_wave_request,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_led_pin,
  output logic                                out_sounder_pin,
  output logic [1:0]                          out_on_mask,
  output logic [albtd_pkg::CNT_W-1:0]         out_bursts_left,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [albtd_pkg::IDX_W-1:0]         cfg_index,
  input  logic [albtd_pkg::DATA_W-1:0]        cfg_data
);
  import albtd_pkg::*;

  // config registers
  logic [FREQ_W-1:0]  freq_r;
  logic [DUTY_W-1:0]  duty_r;
  logic [PULSE_W-1:0] pulse_r;
  logic               led_ah_r;
  logic               buz_ah_r;
  logic               wave_en_r;

  // driver state
  logic               led_on_r,       led_on_nxt;
  logic               buzzer_on_r,    buzzer_on_nxt;
  logic               wave_mode_r,    wave_mode_nxt;
  logic               wave_running_r, wave_running_nxt;
  logic               wave_level_r,   wave_level_nxt;
  logic [CNT_W-1:0]   periods_r,      periods_nxt;
  logic [P_W-1:0]     phase_r,        phase_nxt;

  // output register
  logic               out_valid_r,    out_valid_nxt;
  logic               led_pin_r;
  logic               buz_pin_r;
  logic [1:0]         on_mask_r;
  logic [CNT_W-1:0]   bursts_r;

  albtd_timing_t      tim;
  logic               tim_start;
  logic               in_xfer;
  logic               load_out;
  logic [P_W-1:0]     phase_inc;

  albtd_timing #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_timing (
    .clk  (clk),
    .rst_n(rst_n),
    .start(tim_start),
    .freq (freq_r),
    .duty (duty_r),
    .pulse(pulse_r),
    .tim  (tim)
  );

  // take input only when the sequencer is idle and the result slot frees up
  assign in_ready  = !tim.busy && (!out_valid_r || out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign phase_inc = phase_r + 1'b1;

  always_comb begin
    led_on_nxt       = led_on_r;
    buzzer_on_nxt    = buzzer_on_r;
    wave_mode_nxt    = wave_mode_r;
    wave_running_nxt = wave_running_r;
    wave_level_nxt   = wave_level_r;
    periods_nxt      = periods_r;
    phase_nxt        = phase_r;
    load_out         = 1'b0;
    tim_start        = 1'b0;

    if (in_xfer) begin
      if (in_command == CMD_TICK) begin
        load_out = 1'b1;
        if (!wave_running_r) begin
          // idle wave: drop the buzzer unless a static level is held
          if (!buzzer_on_r || wave_mode_r) begin
            wave_level_nxt = 1'b0;
            periods_nxt    = '0;
          end
        end else begin
          phase_nxt = phase_inc;
          if (wave_level_r) begin
            if (phase_inc >= tim.high) begin
              wave_level_nxt = 1'b0;
              phase_nxt      = '0;
            end
          end else if (phase_inc >= tim.low) begin
            if (periods_r == CNT_W'(1)) begin
              // burst exhausted: force stop
              wave_running_nxt = 1'b0;
              wave_level_nxt   = 1'b0;
              periods_nxt      = '0;
              phase_nxt        = '0;
            end else begin
              if (periods_r != '0) periods_nxt = periods_r - 1'b1;
              phase_nxt      = '0;
              wave_level_nxt = (tim.high != '0);
            end
          end
        end
      end else begin
        led_on_nxt    = in_led_request;
        buzzer_on_nxt = in_buzzer_request;
        wave_mode_nxt = in_wave_request && wave_en_r;
        if (in_wave_request && wave_en_r) begin
          // result follows once the timing is computed
          tim_start = 1'b1;
        end else begin
          wave_running_nxt = 1'b0;
          wave_level_nxt   = in_buzzer_request;
          periods_nxt      = '0;
          load_out         = 1'b1;
        end
      end
    end else if (tim.done) begin
      load_out         = 1'b1;
      wave_running_nxt = buzzer_on_r;
      if (buzzer_on_r) begin
        periods_nxt    = tim.cycles;
        phase_nxt      = '0;
        wave_level_nxt = (tim.high != '0);
      end else begin
        wave_level_nxt = 1'b0;
        periods_nxt    = '0;
      end
    end

    out_valid_nxt = load_out ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r         <= 20'd2731;
      duty_r         <= 7'd50;
      pulse_r        <= '0;
      led_ah_r       <= 1'b1;
      buz_ah_r       <= 1'b1;
      wave_en_r      <= 1'b1;
      led_on_r       <= 1'b0;
      buzzer_on_r    <= 1'b0;
      wave_mode_r    <= 1'b0;
      wave_running_r <= 1'b0;
      wave_level_r   <= 1'b0;
      periods_r      <= '0;
      phase_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FREQ:    freq_r    <= cfg_data[FREQ_W-1:0];
          REG_DUTY:    duty_r    <= cfg_data[DUTY_W-1:0];
          REG_PULSE:   pulse_r   <= cfg_data[PULSE_W-1:0];
          REG_LED_AH:  led_ah_r  <= cfg_data[0];
          REG_BUZ_AH:  buz_ah_r  <= cfg_data[0];
          REG_WAVE_EN: wave_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      led_on_r       <= led_on_nxt;
      buzzer_on_r    <= buzzer_on_nxt;
      wave_mode_r    <= wave_mode_nxt;
      wave_running_r <= wave_running_nxt;
      wave_level_r   <= wave_level_nxt;
      periods_r      <= periods_nxt;
      phase_r        <= phase_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    // hold the payload until the next result is loaded
    if (load_out) begin
      led_pin_r <= (led_on_nxt == led_ah_r);
      buz_pin_r <= (wave_level_nxt == buz_ah_r);
      on_mask_r <= {buzzer_on_nxt, led_on_nxt};
      bursts_r  <= periods_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_pin     = led_pin_r;
  assign out_sounder_pin = buz_pin_r;
  assign out_on_mask     = on_mask_r;
  assign out_bursts_left = bursts_r;

endmodule

`default_nettype wire

// ===== hw/rtl/albtd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on albtd_pkg (request / response structs, widths).
`default_nettype none

module albtd_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  albtd_pkg::albtd_div_req_t req,
  output albtd_pkg::albtd_div_rsp_t rsp
);
  import albtd_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] dq_r, dq_nxt;
  logic [P_W:0]      rem_r, rem_nxt;
  logic [P_W-1:0]    dvs_r, dvs_nxt;
  logic [P_W:0]      rem_sh;
  logic              q_bit;

  always_comb begin
    rem_sh   = {rem_r[P_W-1:0], dq_r[DIVD_W-1]};
    q_bit    = (rem_sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      dq_nxt   = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      rem_nxt = q_bit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      dq_nxt  = {dq_r[DIVD_W-2:0], q_bit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule

`default_nettype wire

// ===== hw/rtl/albtd_timing.sv =====
// Sequencer computing period, high/low time and burst count on the shared divider.
// Depends on albtd_pkg and instantiates albtd_div.
`default_nettype none

module albtd_timing #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [albtd_pkg::FREQ_W-1:0]        freq,
  input  logic [albtd_pkg::DUTY_W-1:0]        duty,
  input  logic [albtd_pkg::PULSE_W-1:0]       pulse,
  output albtd_pkg::albtd_timing_t            tim
);
  import albtd_pkg::*;

  localparam logic [P_W-1:0] TPS_V = P_W'(TICKS_PER_SECOND);
  localparam logic [9:0]     TPM_V = 10'(TICKS_PER_SECOND / 1000);

  albtd_tstate_t    state_r, state_nxt;
  albtd_div_req_t   div_req;
  albtd_div_rsp_t   div_rsp;

  logic [P_W-1:0]    period_r;
  logic [P_W-1:0]    high_r;
  logic [P_W-1:0]    low_r;
  logic [CNT_W-1:0]  cycles_r;
  logic [FREQ_W-1:0] freq_eff;
  logic [DIVD_W-1:0] duty_prod;
  logic [CNT_W-1:0]  span;
  logic [DIVD_W-1:0] h_raw;
  logic [P_W-1:0]    h_clamp;

  albtd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    freq_eff  = (freq == '0) ? FREQ_FALLBACK : freq;
    duty_prod = {{(DIVD_W-P_W){1'b0}}, period_r} * {{(DIVD_W-DUTY_W){1'b0}}, duty};
    span      = {{(CNT_W-PULSE_W){1'b0}}, pulse} * {{(CNT_W-10){1'b0}}, TPM_V};
    // high time: at least 1, at most period-1 (0 when the period is 1)
    h_raw     = (div_rsp.quotient == '0) ? DIVD_W'(1) : div_rsp.quotient;
    h_clamp   = (h_raw >= {{(DIVD_W-P_W){1'b0}}, period_r}) ? (period_r - 1'b1)
                                                            : h_raw[P_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TS_IDLE:    if (start) state_nxt = TS_ISSUE_P;
      TS_ISSUE_P: state_nxt = TS_WAIT_P;
      TS_WAIT_P:  if (div_rsp.done) state_nxt = TS_ISSUE_H;
      TS_ISSUE_H: state_nxt = TS_WAIT_H;
      TS_WAIT_H: begin
        if (div_rsp.done) state_nxt = (pulse != '0) ? TS_ISSUE_C : TS_FINISH;
      end
      TS_ISSUE_C: state_nxt = TS_WAIT_C;
      TS_WAIT_C:  if (div_rsp.done) state_nxt = TS_FINISH;
      TS_FINISH:  state_nxt = TS_IDLE;
      default:    state_nxt = TS_IDLE;
    endcase
  end

  // outputs: divider requests per step
  always_comb begin
    div_req = '0;
    unique case (state_r)
      TS_ISSUE_P: begin
        div_req.start    = 1'b1;
        div_req.dividend = {TPS_V, {(DIVD_W-P_W){1'b0}}};
        div_req.divisor  = freq_eff;
        div_req.steps    = STEPS_PERIOD;
      end
      TS_ISSUE_H: begin
        div_req.start    = 1'b1;
        div_req.dividend = duty_prod;
        div_req.divisor  = DUTY_DIV;
        div_req.steps    = STEPS_HIGH;
      end
      TS_ISSUE_C: begin
        div_req.start    = 1'b1;
        div_req.dividend = {span, {(DIVD_W-CNT_W){1'b0}}};
        div_req.divisor  = period_r;
        div_req.steps    = STEPS_BURST;
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == TS_WAIT_P && div_rsp.done) begin
      period_r <= (div_rsp.quotient == '0) ? P_W'(1) : div_rsp.quotient[P_W-1:0];
    end
    if (state_r == TS_WAIT_H && div_rsp.done) begin
      high_r   <= h_clamp;
      low_r    <= period_r - h_clamp;
      cycles_r <= '0;
    end
    if (state_r == TS_WAIT_C && div_rsp.done) begin
      cycles_r <= (div_rsp.quotient[CNT_W-1:0] == '0) ? CNT_W'(1)
                                                      : div_rsp.quotient[CNT_W-1:0];
    end
  end

  assign tim.busy   = (state_r != TS_IDLE);
  assign tim.done   = (state_r == TS_FINISH);
  assign tim.high   = high_r;
  assign tim.low    = low_r;
  assign tim.cycles = cycles_r;

endmodule

`default_nettype wire
